// ===== sv/pfa_pkg.sv =====
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared types, constants and microprogram for the prime field ALU.
// ----------------------------------------------------------------------------
package pfa_pkg;

    localparam int unsigned FIELD_W = 30;
    localparam logic [FIELD_W-1:0] FIELD_PRIME = 30'd998244353;
    localparam logic [FIELD_W-1:0] EXP_INV     = FIELD_PRIME - 30'd2;
    localparam logic [31:0]        PRIME_X2    = {1'b0, FIELD_PRIME, 1'b0};

    // Barrett constant for 60-bit products: floor(2^60 / P), 31 bits wide
    localparam logic [63:0] BARRETT_MU_64 = (64'd1 << 60) / 64'(FIELD_PRIME);
    localparam logic [30:0] BARRETT_MU    = BARRETT_MU_64[30:0];

    localparam int unsigned EXP_BITS = FIELD_W;
    localparam int unsigned BIT_W    = $clog2(EXP_BITS);

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_opcode;

    typedef struct packed {
        t_opcode            opcode;
        logic [FIELD_W-1:0] operand_a;
        logic [FIELD_W-1:0] operand_b;
    } t_in_word;

    typedef struct packed {
        logic [FIELD_W-1:0] result;
    } t_out_word;

    // Microprogram step addresses
    typedef logic [3:0] t_step;

    localparam t_step ST_IDLE      = 4'd0;
    localparam t_step ST_DISPATCH  = 4'd1;
    localparam t_step ST_ADD       = 4'd2;
    localparam t_step ST_SUB       = 4'd3;
    localparam t_step ST_MUL_GO    = 4'd4;
    localparam t_step ST_MUL_WAIT  = 4'd5;
    localparam t_step ST_DIV_INIT  = 4'd6;
    localparam t_step ST_BIT_TEST  = 4'd7;
    localparam t_step ST_ACC_GO    = 4'd8;
    localparam t_step ST_ACC_WAIT  = 4'd9;
    localparam t_step ST_LAST_TEST = 4'd10;
    localparam t_step ST_SQ_GO     = 4'd11;
    localparam t_step ST_SQ_WAIT   = 4'd12;
    localparam t_step ST_FIN_GO    = 4'd13;
    localparam t_step ST_FIN_WAIT  = 4'd14;
    localparam t_step ST_OUT       = 4'd15;

    typedef enum logic [2:0] {
        BR_NEXT     = 3'd0,
        BR_GOTO     = 3'd1,
        BR_WAIT_IN  = 3'd2,
        BR_DISPATCH = 3'd3,
        BR_WAIT_MUL = 3'd4,
        BR_BIT_CLR  = 3'd5,
        BR_LAST_BIT = 3'd6,
        BR_WAIT_OUT = 3'd7
    } t_branch;

    typedef enum logic [1:0] {
        XS_A   = 2'd0,
        XS_ACC = 2'd1,
        XS_SQ  = 2'd2
    } t_xsel;

    typedef enum logic [1:0] {
        YS_B   = 2'd0,
        YS_SQ  = 2'd1,
        YS_ACC = 2'd2
    } t_ysel;

    typedef enum logic [1:0] {
        DS_NONE = 2'd0,
        DS_ACC  = 2'd1,
        DS_SQ   = 2'd2,
        DS_RES  = 2'd3
    } t_dest;

    typedef struct packed {
        t_branch br;
        t_step   target;
        logic    mul_go;
        t_xsel   xsel;
        t_ysel   ysel;
        t_dest   mul_dest;
        logic    init_exp;
        logic    bit_inc;
        logic    wr_add;
        logic    wr_sub;
    } t_ucw;

    typedef struct packed {
        t_opcode opcode;
        logic    in_fire;
        logic    mul_done;
        logic    bit_clr;
        logic    last_bit;
        logic    out_free;
    } t_dp_status;

    function automatic t_ucw ucode(input t_step step);
        t_ucw w;
        w = '0;
        case (step)
            ST_IDLE:      w.br = BR_WAIT_IN;
            ST_DISPATCH:  w.br = BR_DISPATCH;
            ST_ADD: begin
                w.wr_add = 1'b1;
                w.br     = BR_GOTO;
                w.target = ST_OUT;
            end
            ST_SUB: begin
                w.wr_sub = 1'b1;
                w.br     = BR_GOTO;
                w.target = ST_OUT;
            end
            ST_MUL_GO: begin
                w.mul_go = 1'b1;
                w.xsel   = XS_A;
                w.ysel   = YS_B;
            end
            ST_MUL_WAIT: begin
                w.br       = BR_WAIT_MUL;
                w.mul_dest = DS_RES;
                w.target   = ST_OUT;
            end
            ST_DIV_INIT:  w.init_exp = 1'b1;
            ST_BIT_TEST: begin
                w.br     = BR_BIT_CLR;
                w.target = ST_LAST_TEST;
            end
            ST_ACC_GO: begin
                w.mul_go = 1'b1;
                w.xsel   = XS_ACC;
                w.ysel   = YS_SQ;
            end
            ST_ACC_WAIT: begin
                w.br       = BR_WAIT_MUL;
                w.mul_dest = DS_ACC;
                w.target   = ST_LAST_TEST;
            end
            ST_LAST_TEST: begin
                w.br     = BR_LAST_BIT;
                w.target = ST_FIN_GO;
            end
            ST_SQ_GO: begin
                w.mul_go  = 1'b1;
                w.xsel    = XS_SQ;
                w.ysel    = YS_SQ;
                w.bit_inc = 1'b1;
            end
            ST_SQ_WAIT: begin
                w.br       = BR_WAIT_MUL;
                w.mul_dest = DS_SQ;
                w.target   = ST_BIT_TEST;
            end
            ST_FIN_GO: begin
                w.mul_go = 1'b1;
                w.xsel   = XS_A;
                w.ysel   = YS_ACC;
            end
            ST_FIN_WAIT: begin
                w.br       = BR_WAIT_MUL;
                w.mul_dest = DS_RES;
                w.target   = ST_OUT;
            end
            ST_OUT: begin
                w.br     = BR_WAIT_OUT;
                w.target = ST_IDLE;
            end
            default: begin
                w.br     = BR_GOTO;
                w.target = ST_IDLE;
            end
        endcase
        return w;
    endfunction

    function automatic t_step dispatch_target(input t_opcode op);
        t_step s;
        case (op)
            OP_ADD:  s = ST_ADD;
            OP_SUB:  s = ST_SUB;
            OP_MUL:  s = ST_MUL_GO;
            OP_DIV:  s = ST_DIV_INIT;
            default: s = ST_IDLE;
        endcase
        return s;
    endfunction

endpackage

// ===== sv/pfa_in_if.sv =====
// ----------------------------------------------------------------------------
// pfa_in_if
// Input channel: valid/ready handshake carrying one operation word.
// ----------------------------------------------------------------------------
interface pfa_in_if;
    import pfa_pkg::*;

    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/pfa_out_if.sv =====
// ----------------------------------------------------------------------------
// pfa_out_if
// Output channel: valid/ready handshake carrying one result word.
// ----------------------------------------------------------------------------
interface pfa_out_if;
    import pfa_pkg::*;

    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/prime_field_alu.sv =====
// ----------------------------------------------------------------------------
// prime_field_alu
// Add, subtract, multiply and divide over the field modulo 998244353.
//
// One word in on i_in (opcode, operand_a, operand_b), one word out on o_out
// (result), both valid/ready; a word moves when valid and ready are high.
// Operands are reduced modulo the prime on entry; results lie in 0 .. P-1.
// Division by zero yields zero.
// A microcoded sequencer steps a small datapath around one shared modular
// multiplier with four pipeline stages. One word is worked on at a time.
// Add and subtract do not use the multiplier; multiply uses it once;
// divide uses it for 57 dependent multiplies (the Fermat inverse by
// square-and-multiply) plus one final multiply.
// The result is shown in the cycle after the last step. i_in.ready is high
// only while the sequencer sits at its idle step.
// Reset returns the sequencer to idle and empties the output register.
// A stalled receiver holds the result in the output register; the next word
// is still taken and computed, and waits at its last step until the slot
// is free.
// ----------------------------------------------------------------------------
module prime_field_alu (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pfa_in_if.sink    i_in,
    pfa_out_if.source o_out
);
    import pfa_pkg::*;

    t_ucw       w_ucw;
    t_dp_status w_status;

    pfa_useq u_useq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_ucw    (w_ucw)
    );

    pfa_dpath u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ucw    (w_ucw),
        .o_status (w_status),
        .i_in     (i_in),
        .o_out    (o_out)
    );

endmodule

// ===== sv/pfa_mulmod.sv =====
// ----------------------------------------------------------------------------
// pfa_mulmod
// Four-stage modular multiplier: 30x30 product, Barrett quotient estimate,
// quotient times prime, then final correction into 0 .. P-1.
// ----------------------------------------------------------------------------
module pfa_mulmod (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_go,
    input  logic [pfa_pkg::FIELD_W-1:0] i_x,
    input  logic [pfa_pkg::FIELD_W-1:0] i_y,
    output logic                        o_valid,
    output logic [pfa_pkg::FIELD_W-1:0] o_result
);
    import pfa_pkg::*;

    logic [3:0]         r_v;
    logic [59:0]        r_prod;
    logic [30:0]        r_q;
    logic [31:0]        r_xlo1;
    logic [31:0]        r_qp;
    logic [31:0]        r_xlo2;
    logic [FIELD_W-1:0] r_res;

    logic [61:0]        w_q2;
    logic [31:0]        w_qp;
    logic [31:0]        w_rem;
    logic [31:0]        w_fix;

    assign w_q2  = 62'(r_prod[59:29]) * 62'(BARRETT_MU);
    assign w_qp  = 32'(r_q) * 32'(FIELD_PRIME);
    assign w_rem = r_xlo2 - r_qp;

    always_comb begin
        if (w_rem >= PRIME_X2) begin
            w_fix = w_rem - PRIME_X2;
        end else if (w_rem >= 32'(FIELD_PRIME)) begin
            w_fix = w_rem - 32'(FIELD_PRIME);
        end else begin
            w_fix = w_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[2:0], i_go};
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 60'(i_x) * 60'(i_y);
        r_q    <= w_q2[61:31];
        r_xlo1 <= r_prod[31:0];
        r_qp   <= w_qp;
        r_xlo2 <= r_xlo1;
        r_res  <= w_fix[FIELD_W-1:0];
    end

    assign o_valid  = r_v[3];
    assign o_result = r_res;

endmodule

// ===== sv/pfa_useq.sv =====
// ----------------------------------------------------------------------------
// pfa_useq
// Microcode sequencer: step counter, control store and branch unit.
// ----------------------------------------------------------------------------
module pfa_useq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pfa_pkg::t_dp_status i_status,
    output pfa_pkg::t_ucw       o_ucw
);
    import pfa_pkg::*;

    t_step r_step;
    t_step n_step;
    t_ucw  w_ucw;
    t_step w_inc;

    assign w_ucw = ucode(r_step);
    assign w_inc = r_step + 4'd1;

    always_comb begin
        case (w_ucw.br)
            BR_NEXT:     n_step = w_inc;
            BR_GOTO:     n_step = w_ucw.target;
            BR_WAIT_IN:  n_step = i_status.in_fire ? w_inc : r_step;
            BR_DISPATCH: n_step = dispatch_target(i_status.opcode);
            BR_WAIT_MUL: n_step = i_status.mul_done ? w_ucw.target : r_step;
            BR_BIT_CLR:  n_step = i_status.bit_clr ? w_ucw.target : w_inc;
            BR_LAST_BIT: n_step = i_status.last_bit ? w_ucw.target : w_inc;
            BR_WAIT_OUT: n_step = i_status.out_free ? w_ucw.target : r_step;
            default:     n_step = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_ucw = w_ucw;

endmodule

// ===== sv/pfa_dpath.sv =====
// ----------------------------------------------------------------------------
// pfa_dpath
// Datapath: operand reduction, add/subtract, exponent registers, shared
// modular multiplier and the output register.
// ----------------------------------------------------------------------------
module pfa_dpath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pfa_pkg::t_ucw       i_ucw,
    output pfa_pkg::t_dp_status o_status,
    pfa_in_if.sink              i_in,
    pfa_out_if.source           o_out
);
    import pfa_pkg::*;

    t_opcode            r_op;
    logic [FIELD_W-1:0] r_a;
    logic [FIELD_W-1:0] r_b;
    logic [FIELD_W-1:0] r_acc;
    logic [FIELD_W-1:0] r_sq;
    logic [FIELD_W-1:0] r_res;
    logic [BIT_W-1:0]   r_bit;
    logic               r_out_valid;
    t_out_word          r_out_data;

    logic               w_in_ready;
    logic               w_in_fire;
    logic               w_out_free;
    logic               w_out_load;
    logic [FIELD_W:0]   w_sum;
    logic [FIELD_W-1:0] w_add;
    logic [FIELD_W-1:0] w_sub;
    logic [FIELD_W-1:0] w_mx;
    logic [FIELD_W-1:0] w_my;
    logic               w_mul_valid;
    logic [FIELD_W-1:0] w_mul_res;
    logic               w_mul_wr;

    function automatic logic [FIELD_W-1:0] reduce(input logic [FIELD_W-1:0] v);
        return (v >= FIELD_PRIME) ? v - FIELD_PRIME : v;
    endfunction

    assign w_in_ready = (i_ucw.br == BR_WAIT_IN);
    assign w_in_fire  = i_in.valid && w_in_ready;
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_out_load = (i_ucw.br == BR_WAIT_OUT) && w_out_free;

    assign w_sum = {1'b0, r_a} + {1'b0, r_b};
    assign w_add = (w_sum >= {1'b0, FIELD_PRIME}) ?
                   FIELD_W'(w_sum - {1'b0, FIELD_PRIME}) : w_sum[FIELD_W-1:0];
    assign w_sub = (r_a >= r_b) ? r_a - r_b :
                   FIELD_W'({1'b0, r_a} + {1'b0, FIELD_PRIME} - {1'b0, r_b});

    always_comb begin
        case (i_ucw.xsel)
            XS_A:    w_mx = r_a;
            XS_ACC:  w_mx = r_acc;
            XS_SQ:   w_mx = r_sq;
            default: w_mx = r_a;
        endcase
        case (i_ucw.ysel)
            YS_B:    w_my = r_b;
            YS_SQ:   w_my = r_sq;
            YS_ACC:  w_my = r_acc;
            default: w_my = r_b;
        endcase
    end

    pfa_mulmod u_mulmod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (i_ucw.mul_go),
        .i_x      (w_mx),
        .i_y      (w_my),
        .o_valid  (w_mul_valid),
        .o_result (w_mul_res)
    );

    assign w_mul_wr = (i_ucw.br == BR_WAIT_MUL) && w_mul_valid;

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_op <= i_in.data.opcode;
            r_a  <= reduce(i_in.data.operand_a);
            r_b  <= reduce(i_in.data.operand_b);
        end
        if (i_ucw.init_exp) begin
            r_acc <= FIELD_W'(1);
            r_sq  <= r_b;
            r_bit <= '0;
        end else if (i_ucw.bit_inc) begin
            r_bit <= r_bit + BIT_W'(1);
        end
        if (i_ucw.wr_add) begin
            r_res <= w_add;
        end else if (i_ucw.wr_sub) begin
            r_res <= w_sub;
        end
        if (w_mul_wr) begin
            case (i_ucw.mul_dest)
                DS_ACC:  r_acc <= w_mul_res;
                DS_SQ:   r_sq  <= w_mul_res;
                DS_RES:  r_res <= w_mul_res;
                default: ;
            endcase
        end
        if (w_out_load) begin
            r_out_data.result <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    assign o_status.opcode   = r_op;
    assign o_status.in_fire  = w_in_fire;
    assign o_status.mul_done = w_mul_valid;
    assign o_status.bit_clr  = !EXP_INV[r_bit];
    assign o_status.last_bit = (r_bit == BIT_W'(EXP_BITS - 1));
    assign o_status.out_free = w_out_free;

endmodule

// ===== sv/pfa_chk.sv =====
// ----------------------------------------------------------------------------
// pfa_chk
// Port-level checks for the prime field ALU, bound to the top level.
// ----------------------------------------------------------------------------
module pfa_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [pfa_pkg::FIELD_W-1:0] i_out_result
);
    import pfa_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_result))
        else $error("result word dropped or changed while stalled");

    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_result < FIELD_PRIME))
        else $error("result not fully reduced");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second word accepted while one is in progress");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("block not idle after reset");

endmodule

bind prime_field_alu pfa_chk u_pfa_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_result (o_out.data.result)
);

// ===== verif/prime_field_alu_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// prime_field_alu_test
// Self-checking bench for the prime field ALU: directed words cover operand
// extremes, every opcode, wrap on add and subtract, and division by zero.
// Random words then run under four idling patterns on both channels. Every
// accepted word is predicted in the bench and each result is checked in order.
// ----------------------------------------------------------------------------
module prime_field_alu_test;
    import pfa_pkg::*;

    localparam logic [FIELD_W-1:0] OPND_MAX = {FIELD_W{1'b1}};

    logic i_clk;
    logic i_rst_n;

    pfa_in_if  in_ch ();
    pfa_out_if out_ch ();

    prime_field_alu dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    logic [FIELD_W-1:0] results_due[$];
    logic [FIELD_W-1:0] result_due;
    int unsigned        mismatches;
    int unsigned        send_idle_pct;
    int unsigned        recv_stall_pct;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("prime_field_alu_test: done, errors");
        $finish;
    end

    function automatic longint unsigned field_mul(input longint unsigned x,
                                                  input longint unsigned y);
        longint unsigned p;
        p = FIELD_PRIME;
        return (x * y) % p;
    endfunction

    function automatic logic [FIELD_W-1:0] field_op(input t_opcode op,
                                                    input logic [FIELD_W-1:0] a,
                                                    input logic [FIELD_W-1:0] b);
        longint unsigned    p;
        longint unsigned    x;
        longint unsigned    y;
        longint unsigned    acc;
        longint unsigned    sq;
        longint unsigned    r;
        logic [FIELD_W-1:0] e;
        p = FIELD_PRIME;
        x = a % p;
        y = b % p;
        case (op)
            OP_ADD: begin
                r = x + y;
                if (r >= p) r = r - p;
            end
            OP_SUB: r = (x >= y) ? x - y : x + p - y;
            OP_MUL: r = field_mul(x, y);
            default: begin
                // Fermat inverse: y^(P-2), zero stays zero
                acc = 1;
                sq  = y;
                e   = EXP_INV;
                while (e != '0) begin
                    if (e[0]) acc = field_mul(acc, sq);
                    sq = field_mul(sq, sq);
                    e  = e >> 1;
                end
                r = field_mul(x, acc);
            end
        endcase
        return r[FIELD_W-1:0];
    endfunction

    function automatic logic [FIELD_W-1:0] pick_operand();
        logic [31:0] raw;
        raw = $urandom;
        case ($urandom_range(9))
            0:       return FIELD_W'($urandom_range(3));
            1:       return FIELD_PRIME - FIELD_W'(2) + FIELD_W'($urandom_range(4));
            2:       return OPND_MAX - FIELD_W'($urandom_range(3));
            default: return raw[FIELD_W-1:0];
        endcase
    endfunction

    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (results_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0d",
                         $time, out_ch.data.result);
                mismatches++;
            end else begin
                result_due = results_due.pop_front();
                if (out_ch.data.result !== result_due) begin
                    $display("%0t: result mismatch, expected %0d, actual %0d",
                             $time, result_due, out_ch.data.result);
                    mismatches++;
                end
            end
        end
    end

    task automatic send_word(input t_opcode op, input logic [FIELD_W-1:0] a,
                             input logic [FIELD_W-1:0] b);
        bit idled;
        idled = 1'b0;
        while ($urandom_range(99) < send_idle_pct) begin
            if (!idled) in_ch.valid <= 1'b0;
            idled = 1'b1;
            @(posedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.data.opcode    <= op;
        in_ch.data.operand_a <= a;
        in_ch.data.operand_b <= b;
        do @(posedge i_clk); while (!in_ch.ready);
        results_due.push_back(field_op(op, a, b));
    endtask

    task automatic run_random(input int unsigned words);
        repeat (words) send_word(t_opcode'($urandom_range(3)), pick_operand(),
                                 pick_operand());
    endtask

    task automatic test_directed();
        send_word(OP_ADD, FIELD_W'(FIELD_PRIME - 1), FIELD_W'(FIELD_PRIME - 1));
        send_word(OP_ADD, '0, '0);
        send_word(OP_ADD, OPND_MAX, OPND_MAX);
        send_word(OP_ADD, FIELD_PRIME, FIELD_W'(5));
        send_word(OP_SUB, FIELD_W'(1), FIELD_W'(2));
        send_word(OP_SUB, '0, FIELD_W'(FIELD_PRIME - 1));
        send_word(OP_SUB, FIELD_W'(FIELD_PRIME - 1), '0);
        send_word(OP_SUB, OPND_MAX, '0);
        send_word(OP_SUB, FIELD_W'(5), FIELD_W'(FIELD_PRIME + 5));
        send_word(OP_MUL, FIELD_W'(FIELD_PRIME - 1), FIELD_W'(FIELD_PRIME - 1));
        send_word(OP_MUL, OPND_MAX, OPND_MAX);
        send_word(OP_MUL, '0, OPND_MAX);
        send_word(OP_MUL, FIELD_W'(FIELD_PRIME + 1), FIELD_W'(7));
        send_word(OP_DIV, FIELD_W'(5), '0);
        send_word(OP_DIV, FIELD_W'(7), FIELD_PRIME);
        send_word(OP_DIV, FIELD_W'(FIELD_PRIME - 1), FIELD_W'(1));
        send_word(OP_DIV, FIELD_W'(1), FIELD_W'(FIELD_PRIME - 1));
        send_word(OP_DIV, OPND_MAX, OPND_MAX);
        send_word(OP_DIV, FIELD_W'(1), FIELD_W'(2));
        send_word(OP_DIV, '0, FIELD_W'(3));
        send_word(OP_DIV, FIELD_W'(123456789), OPND_MAX);
    endtask

    task automatic test_streaming();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random(175);
    endtask

    task automatic test_sender_gaps();
        send_idle_pct  = 78;
        recv_stall_pct = 0;
        run_random(175);
    endtask

    task automatic test_receiver_stalls();
        send_idle_pct  = 0;
        recv_stall_pct = 78;
        run_random(175);
    endtask

    task automatic test_mixed_idling();
        send_idle_pct  = 36;
        recv_stall_pct = 36;
        run_random(175);
    endtask

    initial begin
        mismatches           = 0;
        send_idle_pct        = 0;
        recv_stall_pct       = 0;
        i_rst_n              = 1'b0;
        in_ch.valid          = 1'b0;
        in_ch.data.opcode    = OP_ADD;
        in_ch.data.operand_a = '0;
        in_ch.data.operand_b = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_streaming();
        test_sender_gaps();
        test_receiver_stalls();
        test_mixed_idling();

        in_ch.valid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("prime_field_alu_test: done, clean");
        end else begin
            $display("prime_field_alu_test: done, errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/pfa_pkg.sv
sv/pfa_in_if.sv
sv/pfa_out_if.sv
sv/pfa_mulmod.sv
sv/pfa_useq.sv
sv/pfa_dpath.sv
sv/prime_field_alu.sv
sv/pfa_chk.sv
verif/prime_field_alu_test.sv
